### rtl/gradient_noise_2d_macros.svh
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef GRADIENT_NOISE_2D_MACROS_SVH
`define GRADIENT_NOISE_2D_MACROS_SVH
`ifndef SYNTH
`define GN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define GN_ASSERT(lbl, prop, msg)
`define GN_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/gn_pkg.sv
package gn_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int GRAD_BITS  = 16;
  localparam int GRAD2_W    = 2 * GRAD_BITS;
  localparam int GRAD_FRAC  = 14;
  localparam int Q_FRAC     = 16;
  localparam int PERM_W     = 8;
  localparam int OCT_W      = 4;
  localparam int OCT_SH     = 4;
  localparam int COORD_W    = 32;
  localparam int LOC_W      = IDX_W + Q_FRAC;
  localparam int MAC_W      = 24;
  localparam int PROD_W     = 2 * MAC_W;
  localparam int DIV_W      = 40;
  localparam int DVS_W      = 4;
  localparam int SUM_W      = 34;
  localparam int FADE_THREE = 3;

  localparam logic [OCT_W-1:0] MAX_OCT = 4'd8;
  localparam logic signed [MAC_W-1:0] FADE_K = MAC_W'(FADE_THREE << Q_FRAC);

  localparam logic [2:0] FN_LOAD_PERM  = 3'd0;
  localparam logic [2:0] FN_LOAD_GRAD1 = 3'd1;
  localparam logic [2:0] FN_LOAD_GRAD2 = 3'd2;
  localparam logic [2:0] FN_NOISE1     = 3'd3;
  localparam logic [2:0] FN_NOISE2     = 3'd4;
  localparam logic [2:0] FN_OCTAVE     = 3'd5;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SCX, ST_SCXW, ST_SCY, ST_SCYW, ST_PI, ST_PJ,
    ST_FX1, ST_FX2, ST_FX3, ST_FY1, ST_FY2, ST_FY3,
    ST_CP, ST_CG, ST_CMX, ST_CMY, ST_CST, ST_G1P, ST_G1M, ST_G1S,
    ST_BA, ST_BAS, ST_BB, ST_BBS, ST_BF, ST_BFS, ST_ND,
    ST_DIV, ST_DIVW, ST_FIN
  } state_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    r = v[COORD_W-1:0];
    if (!v[SUM_W-1] && (v[SUM_W-2:COORD_W-1] != '0))
      r = {1'b0, {(COORD_W-1){1'b1}}};
    else if (v[SUM_W-1] && (v[SUM_W-2:COORD_W-1] != '1))
      r = {1'b1, {(COORD_W-1){1'b0}}};
    return r;
  endfunction

endpackage

### rtl/gn_ram.sv
module gn_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata_r
);

  logic [W-1:0] mem_r [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

### rtl/gn_div.sv
module gn_div import gn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0]        divisor,
  output logic                    busy,
  output logic                    done,
  output logic [DIV_W-1:0]        quot
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             neg_r;
  logic [DIV_W-1:0] q_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] d_r;
  logic [DVS_W-1:0] trial;

  // floor division: negative dividends go through one's complement
  assign trial = {rem_r[DVS_W-2:0], q_r[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[DIV_W-1];
      q_r   <= dividend[DIV_W-1] ? ~dividend : dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      if (trial >= d_r) begin
        rem_r <= trial - d_r;
        q_r   <= {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = neg_r ? ~q_r : q_r;

endmodule

### rtl/gn_mac.sv
module gn_mac import gn_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     acc,
  input  logic signed [MAC_W-1:0]  a,
  input  logic signed [MAC_W-1:0]  b,
  output logic signed [PROD_W-1:0] p_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= (acc ? p_r : PROD_W'(0)) + a * b;
    end
  end

endmodule

### rtl/gradient_noise_2d.sv
// Classic 2D gradient noise in fixed point (Q16.16 coordinates and result, Q1.14
// gradients). Load transactions write the permutation, 1D and 2D gradient tables and
// return zero; tables must be written before they are read. One transaction is in
// work at a time and in_ready is high only when idle; the result sits in an output
// register, so the next transaction can start while it waits. Transactions compute
// 1D noise, 2D noise or an octave sum of n octaves. All products go through one
// shared multiply-accumulate unit; octave scaling and weighting go through one
// 40-step bit-serial divider.
`include "gradient_noise_2d_macros.svh"

module gradient_noise_2d import gn_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                in_func,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic [OCT_W-1:0]          in_octave_count,
  input  logic [7:0]                in_table_index,
  input  logic [7:0]                in_perm_value,
  input  logic signed [15:0]        in_grad_x,
  input  logic signed [15:0]        in_grad_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] out_noise_value
);

  state_t state_r, state_nxt;

  logic                      md1_r, oct_r;
  logic [COORD_W-1:0]        xin_r, yin_r;
  logic [LOC_W-1:0]          xc_r, yc_r;
  logic [OCT_W-1:0]          oct_n_r, oct_i_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic [IDX_W-1:0]          pi_r, pj_r;
  logic signed [MAC_W-1:0]   sx_r, sy_r, noise_r;
  logic signed [MAC_W-1:0]   c_r [4];
  logic [1:0]                k_r;
  logic signed [COORD_W-1:0] res_r, out_noise_value_r;
  logic                      out_valid_r;

  logic                      accept;
  logic [OCT_W-1:0]          oct_sat;
  logic [Q_FRAC-1:0]         fx, fy;
  logic [IDX_W-1:0]          cx, cy, sel_p;
  logic signed [MAC_W-1:0]   ox0, ox1, oy0, oy1, p_sh16, p_sh14;
  logic signed [SUM_W-1:0]   sum_add;

  logic                      mac_en, mac_acc;
  logic signed [MAC_W-1:0]   mac_a, mac_b;
  logic signed [PROD_W-1:0]  p_r;

  logic                      perm_re, grad1_re, grad2_re;
  logic [IDX_W-1:0]          perm_raddr, grad1_raddr, grad2_raddr;
  logic [PERM_W-1:0]         perm_rd;
  logic [GRAD_BITS-1:0]      grad1_rd;
  logic [GRAD2_W-1:0]        grad2_rd;

  logic                      div_start, div_busy, div_done;
  logic signed [DIV_W-1:0]   div_dvd;
  logic [DVS_W-1:0]          div_dvs;
  logic [DIV_W-1:0]          div_q;

  function automatic logic signed [DIV_W-1:0] scale(input logic [COORD_W-1:0] v,
                                                    input logic [OCT_W-1:0] sh);
    logic signed [DIV_W-1:0] e;
    e = {{(DIV_W-COORD_W){v[COORD_W-1]}}, v};
    e = e <<< sh;
    return e >>> OCT_SH;
  endfunction

  assign accept  = in_valid && in_ready;
  assign oct_sat = (in_octave_count > MAX_OCT) ? MAX_OCT : in_octave_count;
  assign fx      = xc_r[Q_FRAC-1:0];
  assign cx      = xc_r[LOC_W-1:Q_FRAC];
  assign fy      = yc_r[Q_FRAC-1:0];
  assign cy      = yc_r[LOC_W-1:Q_FRAC];
  assign sel_p   = k_r[0] ? pj_r : pi_r;
  // second offset t - 1 is the fraction with all upper bits set
  assign ox0     = {{(MAC_W-Q_FRAC){1'b0}}, fx};
  assign ox1     = {{(MAC_W-Q_FRAC){1'b1}}, fx};
  assign oy0     = {{(MAC_W-Q_FRAC){1'b0}}, fy};
  assign oy1     = {{(MAC_W-Q_FRAC){1'b1}}, fy};
  assign p_sh16  = p_r[Q_FRAC+MAC_W-1:Q_FRAC];
  assign p_sh14  = p_r[GRAD_FRAC+MAC_W-1:GRAD_FRAC];
  assign sum_add = sum_r + div_q[SUM_W-1:0];

  gn_mac u_mac (
    .clk (clk),
    .en  (mac_en),
    .acc (mac_acc),
    .a   (mac_a),
    .b   (mac_b),
    .p_r (p_r)
  );

  gn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_q)
  );

  gn_ram #(.W(PERM_W), .D(TABLE_SIZE)) u_perm (
    .clk     (clk),
    .we      (accept && (in_func == FN_LOAD_PERM)),
    .waddr   (in_table_index[IDX_W-1:0]),
    .wdata   (in_perm_value),
    .re      (perm_re),
    .raddr   (perm_raddr),
    .rdata_r (perm_rd)
  );

  gn_ram #(.W(GRAD_BITS), .D(TABLE_SIZE)) u_grad1 (
    .clk     (clk),
    .we      (accept && (in_func == FN_LOAD_GRAD1)),
    .waddr   (in_table_index[IDX_W-1:0]),
    .wdata   (in_grad_x),
    .re      (grad1_re),
    .raddr   (grad1_raddr),
    .rdata_r (grad1_rd)
  );

  gn_ram #(.W(GRAD2_W), .D(TABLE_SIZE)) u_grad2 (
    .clk     (clk),
    .we      (accept && (in_func == FN_LOAD_GRAD2)),
    .waddr   (in_table_index[IDX_W-1:0]),
    .wdata   ({in_grad_x, in_grad_y}),
    .re      (grad2_re),
    .raddr   (grad2_raddr),
    .rdata_r (grad2_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    mac_en      = 1'b0;
    mac_acc     = 1'b0;
    mac_a       = '0;
    mac_b       = '0;
    perm_re     = 1'b0;
    perm_raddr  = cx;
    grad1_re    = 1'b0;
    grad1_raddr = sel_p;
    grad2_re    = 1'b0;
    grad2_raddr = perm_rd[IDX_W-1:0];
    div_start   = 1'b0;
    div_dvd     = scale(xin_r, oct_i_r);
    div_dvs     = oct_n_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if ((in_func == FN_NOISE1) || (in_func == FN_NOISE2)) begin
            state_nxt = ST_PI;
          end else if ((in_func == FN_OCTAVE) && (oct_sat != '0)) begin
            state_nxt = ST_SCX;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_SCX: begin
        div_start = 1'b1;
        state_nxt = ST_SCXW;
      end
      ST_SCXW: begin
        if (div_done) begin
          state_nxt = ST_SCY;
        end
      end
      ST_SCY: begin
        div_start = 1'b1;
        div_dvd   = scale(yin_r, oct_i_r);
        state_nxt = ST_SCYW;
      end
      ST_SCYW: begin
        if (div_done) begin
          state_nxt = ST_PI;
        end
      end
      ST_PI: begin
        perm_re   = 1'b1;
        state_nxt = ST_PJ;
      end
      ST_PJ: begin
        perm_re    = 1'b1;
        perm_raddr = cx + 1'b1;
        state_nxt  = ST_FX1;
      end
      ST_FX1: begin
        mac_en    = 1'b1;
        mac_a     = ox0;
        mac_b     = ox0;
        state_nxt = ST_FX2;
      end
      ST_FX2: begin
        mac_en    = 1'b1;
        mac_a     = p_sh16;
        mac_b     = FADE_K - (ox0 <<< 1);
        state_nxt = ST_FX3;
      end
      ST_FX3: begin
        state_nxt = md1_r ? ST_G1P : ST_FY1;
      end
      ST_FY1: begin
        mac_en    = 1'b1;
        mac_a     = oy0;
        mac_b     = oy0;
        state_nxt = ST_FY2;
      end
      ST_FY2: begin
        mac_en    = 1'b1;
        mac_a     = p_sh16;
        mac_b     = FADE_K - (oy0 <<< 1);
        state_nxt = ST_FY3;
      end
      ST_FY3: begin
        state_nxt = ST_CP;
      end
      ST_CP: begin
        perm_re    = 1'b1;
        perm_raddr = sel_p + cy + {{(IDX_W-1){1'b0}}, k_r[1]};
        state_nxt  = ST_CG;
      end
      ST_CG: begin
        grad2_re  = 1'b1;
        state_nxt = ST_CMX;
      end
      ST_CMX: begin
        mac_en    = 1'b1;
        mac_a     = k_r[0] ? ox1 : ox0;
        mac_b     = MAC_W'($signed(grad2_rd[GRAD2_W-1:GRAD_BITS]));
        state_nxt = ST_CMY;
      end
      ST_CMY: begin
        mac_en    = 1'b1;
        mac_acc   = 1'b1;
        mac_a     = k_r[1] ? oy1 : oy0;
        mac_b     = MAC_W'($signed(grad2_rd[GRAD_BITS-1:0]));
        state_nxt = ST_CST;
      end
      ST_CST: begin
        state_nxt = (k_r == 2'd3) ? ST_BA : ST_CP;
      end
      ST_G1P: begin
        grad1_re  = 1'b1;
        state_nxt = ST_G1M;
      end
      ST_G1M: begin
        mac_en    = 1'b1;
        mac_a     = k_r[0] ? ox1 : ox0;
        mac_b     = MAC_W'($signed(grad1_rd));
        state_nxt = ST_G1S;
      end
      ST_G1S: begin
        state_nxt = k_r[0] ? ST_BA : ST_G1P;
      end
      ST_BA: begin
        mac_en    = 1'b1;
        mac_a     = sx_r;
        mac_b     = c_r[1] - c_r[0];
        state_nxt = ST_BAS;
      end
      ST_BAS: begin
        state_nxt = md1_r ? ST_ND : ST_BB;
      end
      ST_BB: begin
        mac_en    = 1'b1;
        mac_a     = sx_r;
        mac_b     = c_r[3] - c_r[2];
        state_nxt = ST_BBS;
      end
      ST_BBS: begin
        state_nxt = ST_BF;
      end
      ST_BF: begin
        mac_en    = 1'b1;
        mac_a     = sy_r;
        mac_b     = c_r[1] - c_r[0];
        state_nxt = ST_BFS;
      end
      ST_BFS: begin
        state_nxt = ST_ND;
      end
      ST_ND: begin
        state_nxt = oct_r ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        div_start = 1'b1;
        div_dvd   = {{(DIV_W-MAC_W){noise_r[MAC_W-1]}}, noise_r};
        div_dvs   = oct_i_r;
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done) begin
          state_nxt = (oct_i_r == oct_n_r) ? ST_FIN : ST_SCX;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        res_r   <= '0;
        xin_r   <= in_coord_x;
        yin_r   <= in_coord_y;
        xc_r    <= in_coord_x[LOC_W-1:0];
        yc_r    <= in_coord_y[LOC_W-1:0];
        md1_r   <= (in_func == FN_NOISE1);
        oct_r   <= (in_func == FN_OCTAVE);
        oct_n_r <= oct_sat;
        oct_i_r <= OCT_W'(1);
        sum_r   <= '0;
      end
      ST_SCXW: begin
        if (div_done) begin
          xc_r <= div_q[LOC_W-1:0];
        end
      end
      ST_SCYW: begin
        if (div_done) begin
          yc_r <= div_q[LOC_W-1:0];
        end
      end
      ST_PJ:  pi_r <= perm_rd[IDX_W-1:0];
      ST_FX1: pj_r <= perm_rd[IDX_W-1:0];
      ST_FX3: begin
        sx_r <= p_sh16;
        k_r  <= 2'd0;
      end
      ST_FY3: begin
        sy_r <= p_sh16;
        k_r  <= 2'd0;
      end
      ST_CST, ST_G1S: begin
        c_r[k_r] <= p_sh14;
        k_r      <= k_r + 1'b1;
      end
      ST_BAS: begin
        c_r[0]  <= c_r[0] + p_sh16;
        noise_r <= c_r[0] + p_sh16;
      end
      ST_BBS: c_r[1] <= c_r[2] + p_sh16;
      ST_BFS: noise_r <= c_r[0] + p_sh16;
      ST_ND: begin
        res_r <= sat32({{(SUM_W-MAC_W){noise_r[MAC_W-1]}}, noise_r});
      end
      ST_DIVW: begin
        if (div_done) begin
          sum_r   <= sum_add;
          oct_i_r <= oct_i_r + 1'b1;
          res_r   <= sat32(sum_add);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_FIN) && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_FIN) && (!out_valid_r || out_ready)) begin
      out_noise_value_r <= res_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_value_r;

  `GN_ASSERT(a_div_wait, div_busy |-> (state_r == ST_SCXW || state_r == ST_SCYW || state_r == ST_DIVW), "divider busy outside a wait state")
  `GN_ASSERT_NEXT(a_load_fin, accept && (in_func == FN_LOAD_PERM || in_func == FN_LOAD_GRAD1 || in_func == FN_LOAD_GRAD2), state_r == ST_FIN, "load transaction did not finish at once")
  `GN_ASSERT(a_oct_idx, (state_r == ST_SCX) |-> (oct_i_r != '0 && oct_i_r <= oct_n_r), "octave index out of range")

endmodule
